// ===== sv/csma_pkg.sv =====
`default_nettype none

package csma_pkg;

    localparam int BACKOFF_BITS_DEF = 16;
    localparam int RND_W            = 16;
    localparam int CNT_W            = $clog2(RND_W);

    // command codes
    localparam logic [1:0] CMD_REQ  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_DONE = 2'd2;

    // action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_DONE = 2'd2;
    localparam logic [1:0] ACT_BUSY = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_MIN      = 2'd1;
    localparam logic [1:0] CFG_MAX_INIT = 2'd2;
    localparam logic [1:0] CFG_MAX_CONG = 2'd3;

    localparam logic        RST_ENABLE   = 1'b1;
    localparam logic [15:0] RST_MIN      = 16'd320;
    localparam logic [15:0] RST_MAX_INIT = 16'd4960;
    localparam logic [15:0] RST_MAX_CONG = 16'd2240;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BACKOFF,
        PH_CONGEST
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        channel_clear;
        logic [15:0] random_value;
        logic [7:0]  tx_status;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  report_status;
        logic [15:0] armed_backoff_us;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/csma_backoff_controller.sv =====
`default_nettype none

// CSMA backoff controller. Items are send requests, microsecond ticks with a
// channel-clear sample, and transmit-done events; each item yields exactly one
// result item. An item passes through EXEC and then PUT, with DIV between them
// when it arms a random backoff over a non-empty span: the draw's modulo runs
// on one shared restoring subtractor that settles one remainder bit per cycle
// over the 16 bits of random_value. Input is stalled while an item is in
// flight; a registered output stage holds the finished result until it is
// taken, so the next item can be accepted meanwhile. Configuration is a plain
// write port and must only be written while the block is idle.
module csma_backoff_controller
    import csma_pkg::*;
#(
    parameter int BACKOFF_BITS = BACKOFF_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int SUM_W = (BACKOFF_BITS > 17) ? BACKOFF_BITS : 17;
    localparam int OUT_W = (BACKOFF_BITS > 16) ? BACKOFF_BITS : 16;

    state_t state_reg, state_next;

    logic        enable_reg;
    logic [15:0] min_reg, max_init_reg, max_cong_reg;

    phase_t                  phase_reg, phase_next;
    logic [BACKOFF_BITS-1:0] remain_reg, remain_next;
    logic                    running_reg, running_next;

    in_item_t    item_reg, item_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic        accept;
    logic        slot_free;
    logic        need_draw;
    logic        expire;
    logic [15:0] hi_sel;
    logic        span_empty;
    logic [15:0] span;
    logic [16:0] trial;
    logic [16:0] draw17;
    logic [SUM_W-1:0] draw_ext;
    logic [BACKOFF_BITS-1:0] arm_val;
    logic [OUT_W-1:0] arm_out_ext;

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign slot_free = !out_valid_reg || !out_stall;

    assign hi_sel     = (item_reg.cmd == CMD_REQ) ? max_init_reg : max_cong_reg;
    assign span_empty = (hi_sel <= min_reg);
    assign span       = hi_sel - min_reg;

    assign expire    = running_reg && (remain_reg <= BACKOFF_BITS'(1));
    assign need_draw = ((item_reg.cmd == CMD_REQ) && enable_reg && (phase_reg == PH_IDLE))
                    || ((item_reg.cmd == CMD_TICK) && expire && !item_reg.channel_clear
                        && (phase_reg == PH_BACKOFF));

    assign trial       = {rem_reg, div_reg[15]};
    assign draw17      = span_empty ? {1'b0, min_reg} : ({1'b0, min_reg} + {1'b0, rem_reg});
    assign draw_ext    = SUM_W'(draw17);
    assign arm_val     = draw_ext[BACKOFF_BITS-1:0];
    assign arm_out_ext = OUT_W'(arm_val);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (need_draw && !span_empty)
                    state_next = ST_DIV;
                else
                    state_next = ST_PUT;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(RND_W - 1))
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    // datapath
    always_comb
    begin
        item_next      = item_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        remain_next    = remain_reg;
        running_next   = running_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (accept)
            item_next = in_data;

        case (state_reg)
            ST_EXEC:
            begin
                rem_next = '0;
                div_next = item_reg.random_value;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, span})
                    rem_next = 16'(trial - {1'b0, span});
                else
                    rem_next = trial[15:0];
                div_next = {div_reg[14:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.action           = ACT_NONE;
                    out_data_next.report_status    = '0;
                    out_data_next.armed_backoff_us = '0;
                    case (item_reg.cmd)
                        CMD_REQ:
                        begin
                            if (!enable_reg)
                                out_data_next.action = ACT_SEND;
                            else if (phase_reg == PH_IDLE)
                            begin
                                phase_next   = PH_BACKOFF;
                                remain_next  = arm_val;
                                running_next = 1'b1;
                                out_data_next.armed_backoff_us = arm_out_ext[15:0];
                            end
                            else
                                out_data_next.action = ACT_BUSY;
                        end
                        CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (!expire)
                                    remain_next = remain_reg - BACKOFF_BITS'(1);
                                else
                                begin
                                    remain_next  = '0;
                                    running_next = 1'b0;
                                    if (item_reg.channel_clear)
                                        out_data_next.action = ACT_SEND;
                                    else if (phase_reg == PH_BACKOFF)
                                    begin
                                        phase_next   = PH_CONGEST;
                                        remain_next  = arm_val;
                                        running_next = 1'b1;
                                        out_data_next.armed_backoff_us = arm_out_ext[15:0];
                                    end
                                    else
                                    begin
                                        phase_next           = PH_IDLE;
                                        out_data_next.action = ACT_BUSY;
                                    end
                                end
                            end
                        end
                        CMD_DONE:
                        begin
                            if (enable_reg)
                                phase_next = PH_IDLE;
                            out_data_next.action        = ACT_DONE;
                            out_data_next.report_status = item_reg.tx_status;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            remain_reg    <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= RST_ENABLE;
            min_reg       <= RST_MIN;
            max_init_reg  <= RST_MAX_INIT;
            max_cong_reg  <= RST_MAX_CONG;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            remain_reg    <= remain_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENABLE:   enable_reg   <= cfg_data[0];
                    CFG_MIN:      min_reg      <= cfg_data;
                    CFG_MAX_INIT: max_init_reg <= cfg_data;
                    CFG_MAX_CONG: max_cong_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
